>>> sv/fractional_delay_line_macros.svh
// ----------------------------------------------------------------------------
// Fractional delay line assertion macros
// Concurrent assertion wrappers for the fractional delay line RTL.
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_DELAY_LINE_MACROS_SVH
`define FRACTIONAL_DELAY_LINE_MACROS_SVH
`ifndef SYNTHESIS
`define FDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FDL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDL_ASSERT(lbl, prop, msg)
`define FDL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/fdl_pkg.sv
// ----------------------------------------------------------------------------
// Fractional delay line package
// Shared constants, register indices, sequencer states and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package fdl_pkg;

  localparam int MAX_LINE_DEF    = 4096;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int LEN_CFG_W  = 13;
  localparam int FRAC_W     = 16;
  localparam int GAIN_W     = 16;

  localparam int OUT_SHIFT  = 28;

  localparam logic [LEN_CFG_W-1:0] LINE_LENGTH_RST = 13'd4096;
  localparam logic [LEN_CFG_W-1:0] DELAY_WHOLE_RST = 13'd4096;
  localparam logic [FRAC_W-1:0]    DELAY_FRAC_RST  = 16'd0;
  localparam logic [GAIN_W-1:0]    MAKEUP_GAIN_RST = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_LENGTH = 8'd0,
    REG_DELAY_WHOLE = 8'd1,
    REG_DELAY_FRAC  = 8'd2,
    REG_MAKEUP_GAIN = 8'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_RD_A,
    ST_RD_B,
    ST_DIFF,
    ST_MUL_F,
    ST_BLEND,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_SUM,
    ST_SAT
  } state_t;

  typedef enum logic [1:0] {
    MUL_DIFF_F,
    MUL_HI_G,
    MUL_LO_G
  } mul_sel_t;

  typedef struct packed {
    logic     clear;
    logic     take_in;
    logic     cap_a;
    logic     cap_diff;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     cap_blend;
    logic     cap_hi;
    logic     cap_sum;
    logic     load_out;
  } ctl_t;

endpackage

`default_nettype wire

>>> sv/fractional_delay_line.sv
// ----------------------------------------------------------------------------
// Fractional delay line
// Circular sample line with linear interpolation, makeup gain and saturation.
// ----------------------------------------------------------------------------
// Samples enter on the in_ channel and one result per sample leaves on the
// out_ channel, both with valid and ready; a beat moves when both are high.
// Each sample reads the stored samples delay_whole and delay_whole plus one
// places back, stores the new sample once both are read, then blends them by
// delay_frac, applies makeup_gain, rounds and saturates.
// A new sample is taken only after the result of the previous one has been
// loaded into the output register, as the sequencer steps one line RAM port
// and one shared multiplier through the work.
// The output register holds a finished result while the receiver stalls;
// the block then waits in its last step until the held result is taken.
// After reset a clearing pass writes zero to all MAX_LINE slots, one a cycle,
// with in_ready low; the registers return to their reset values. Register
// writes on the cfg_ channel are taken in every cycle and should be made
// only while no sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module fractional_delay_line #(
  parameter int MAX_LINE    = fdl_pkg::MAX_LINE_DEF,
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_sample_in,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic signed [SAMPLE_BITS-1:0]   out_sample_out,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [fdl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fdl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_LINE);

  logic [fdl_pkg::LEN_CFG_W-1:0] line_length_r, line_length_nxt;
  logic [fdl_pkg::LEN_CFG_W-1:0] delay_whole_r, delay_whole_nxt;
  logic [fdl_pkg::FRAC_W-1:0]    delay_frac_r, delay_frac_nxt;
  logic [fdl_pkg::GAIN_W-1:0]    makeup_gain_r, makeup_gain_nxt;

  fdl_pkg::ctl_t              ctl;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [AW-1:0]              ram_raddr;
  logic [SAMPLE_BITS-1:0]     ram_wdata;
  logic [SAMPLE_BITS-1:0]     ram_rdata;
  logic [fdl_pkg::FRAC_W-1:0] frac;
  logic [SAMPLE_BITS-1:0]     sample_out;

  assign cfg_ready = 1'b1;

  always_comb begin
    line_length_nxt = line_length_r;
    delay_whole_nxt = delay_whole_r;
    delay_frac_nxt  = delay_frac_r;
    makeup_gain_nxt = makeup_gain_r;
    if (cfg_valid) begin
      case (cfg_index)
        fdl_pkg::REG_LINE_LENGTH: line_length_nxt = cfg_data[fdl_pkg::LEN_CFG_W-1:0];
        fdl_pkg::REG_DELAY_WHOLE: delay_whole_nxt = cfg_data[fdl_pkg::LEN_CFG_W-1:0];
        fdl_pkg::REG_DELAY_FRAC:  delay_frac_nxt  = cfg_data;
        fdl_pkg::REG_MAKEUP_GAIN: makeup_gain_nxt = cfg_data;
        default:                  line_length_nxt = line_length_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= fdl_pkg::LINE_LENGTH_RST;
      delay_whole_r <= fdl_pkg::DELAY_WHOLE_RST;
      delay_frac_r  <= fdl_pkg::DELAY_FRAC_RST;
      makeup_gain_r <= fdl_pkg::MAKEUP_GAIN_RST;
    end else begin
      line_length_r <= line_length_nxt;
      delay_whole_r <= delay_whole_nxt;
      delay_frac_r  <= delay_frac_nxt;
      makeup_gain_r <= makeup_gain_nxt;
    end
  end

  fdl_ctrl #(
    .MAX_LINE (MAX_LINE)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .line_length (line_length_r),
    .delay_whole (delay_whole_r),
    .delay_frac  (delay_frac_r),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_raddr   (ram_raddr),
    .frac        (frac),
    .ctl         (ctl)
  );

  fdl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LINE)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fdl_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .ctl        (ctl),
    .sample_in  (in_sample_in),
    .frac       (frac),
    .gain       (makeup_gain_r),
    .ram_rdata  (ram_rdata),
    .ram_wdata  (ram_wdata),
    .sample_out (sample_out)
  );

  assign out_sample_out = $signed(sample_out);

endmodule

`default_nettype wire

>>> sv/fdl_ram.sv
// ----------------------------------------------------------------------------
// Fractional delay line RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output      logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/fdl_dp.sv
// ----------------------------------------------------------------------------
// Fractional delay line datapath
// Interpolation, gain and saturation built around one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_dp #(
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire fdl_pkg::ctl_t                 ctl,
  input  wire logic [SAMPLE_BITS-1:0]        sample_in,
  input  wire logic [fdl_pkg::FRAC_W-1:0]    frac,
  input  wire logic [fdl_pkg::GAIN_W-1:0]    gain,
  input  wire logic [SAMPLE_BITS-1:0]        ram_rdata,
  output      logic [SAMPLE_BITS-1:0]        ram_wdata,
  output      logic [SAMPLE_BITS-1:0]        sample_out
);

  localparam int S    = SAMPLE_BITS;
  localparam int DW   = S + 1;
  localparam int MB   = 17;
  localparam int MA   = (DW > MB) ? DW : MB;
  localparam int PW   = MA + MB;
  localparam int BW   = S + 17;
  localparam int ACCW = S + 34;
  localparam int RW   = S + 6;
  localparam longint SMAX = (longint'(1) << (S - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint RND  = longint'(1) << (fdl_pkg::OUT_SHIFT - 1);

  logic        [S-1:0]    sample_r;
  logic signed [S-1:0]    a_r;
  logic signed [DW-1:0]   diff_r;
  logic signed [PW-1:0]   mul_r;
  logic signed [BW-1:0]   blend_r;
  logic signed [PW-1:0]   hi_r;
  logic signed [RW-1:0]   res_r;
  logic        [S-1:0]    out_r;

  logic signed [MA-1:0]   op_a;
  logic signed [MB-1:0]   op_b;
  logic signed [PW-1:0]   mul_full;
  logic signed [DW-1:0]   diff_nxt;
  logic signed [BW-1:0]   blend_nxt;
  logic signed [ACCW-1:0] acc;
  logic signed [RW-1:0]   res_nxt;
  logic        [S-1:0]    out_nxt;

  always_comb begin
    case (ctl.mul_sel)
      fdl_pkg::MUL_DIFF_F: begin
        op_a = MA'(diff_r);
        op_b = $signed({1'b0, frac});
      end
      fdl_pkg::MUL_HI_G: begin
        op_a = MA'($signed(blend_r[BW-1:16]));
        op_b = $signed({1'b0, gain});
      end
      fdl_pkg::MUL_LO_G: begin
        op_a = MA'($signed({1'b0, blend_r[15:0]}));
        op_b = $signed({1'b0, gain});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_full  = PW'(op_a) * PW'(op_b);
  assign diff_nxt  = DW'($signed(ram_rdata)) - DW'(a_r);
  assign blend_nxt = (BW'(a_r) <<< 16) + BW'(mul_r);
  assign acc       = (ACCW'(hi_r) <<< 16) + ACCW'(mul_r) + ACCW'(RND);
  assign res_nxt   = RW'(acc >>> fdl_pkg::OUT_SHIFT);

  always_comb begin
    if (res_r > RW'(SMAX)) begin
      out_nxt = S'(SMAX);
    end else if (res_r < RW'(SMIN)) begin
      out_nxt = S'(SMIN);
    end else begin
      out_nxt = S'(res_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      sample_r <= sample_in;
    end
    if (ctl.cap_a) begin
      a_r <= $signed(ram_rdata);
    end
    if (ctl.cap_diff) begin
      diff_r <= diff_nxt;
    end
    if (ctl.mul_en) begin
      mul_r <= mul_full;
    end
    if (ctl.cap_blend) begin
      blend_r <= blend_nxt;
    end
    if (ctl.cap_hi) begin
      hi_r <= mul_r;
    end
    if (ctl.cap_sum) begin
      res_r <= res_nxt;
    end
    if (ctl.load_out) begin
      out_r <= out_nxt;
    end
  end

  assign ram_wdata  = ctl.clear ? '0 : sample_r;
  assign sample_out = out_r;

endmodule

`default_nettype wire

>>> sv/fdl_ctrl.sv
// ----------------------------------------------------------------------------
// Fractional delay line sequencer
// Clearing pass, address generation, write position and step control.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fractional_delay_line_macros.svh"

module fdl_ctrl #(
  parameter int MAX_LINE = fdl_pkg::MAX_LINE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic                           out_ready,
  output      logic                           out_valid,
  input  wire logic [fdl_pkg::LEN_CFG_W-1:0]  line_length,
  input  wire logic [fdl_pkg::LEN_CFG_W-1:0]  delay_whole,
  input  wire logic [fdl_pkg::FRAC_W-1:0]     delay_frac,
  output      logic                           ram_we,
  output      logic [$clog2(MAX_LINE)-1:0]    ram_waddr,
  output      logic [$clog2(MAX_LINE)-1:0]    ram_raddr,
  output      logic [fdl_pkg::FRAC_W-1:0]     frac,
  output      fdl_pkg::ctl_t                  ctl
);

  localparam int AW = $clog2(MAX_LINE);
  localparam int LW = AW + 1;

  fdl_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]             clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]             wp_r, wp_nxt;
  logic [AW-1:0]             wpe_r, wpe_nxt;
  logic [LW-1:0]             len_r, len_nxt;
  logic [LW-1:0]             dly_r, dly_nxt;
  logic [fdl_pkg::FRAC_W-1:0] frac_r, frac_nxt;
  logic [AW-1:0]             rd0_r, rd0_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [LW-1:0]             len_c;
  logic [LW-1:0]             dly_c;
  logic [AW-1:0]             wp_c;
  logic [LW-1:0]             back;
  logic [AW-1:0]             rd1;
  logic [LW-1:0]             wp_inc;
  logic                      clr_last;
  logic                      load_ok;

  // Effective line length, delay and write position from the registers.
  always_comb begin
    if (32'(line_length) < 32'd2) begin
      len_c = LW'(2);
    end else if (32'(line_length) > 32'(MAX_LINE)) begin
      len_c = LW'(MAX_LINE);
    end else begin
      len_c = LW'(line_length);
    end
    if (delay_whole == '0) begin
      dly_c = LW'(1);
    end else if (32'(delay_whole) > 32'(len_c)) begin
      dly_c = len_c;
    end else begin
      dly_c = LW'(delay_whole);
    end
    wp_c = ({1'b0, wp_r} >= len_c) ? '0 : wp_r;
  end

  assign back     = {1'b0, wpe_r} - dly_r;
  assign rd1      = (rd0_r == '0) ? AW'(len_r - LW'(1)) : rd0_r - AW'(1);
  assign wp_inc   = {1'b0, wpe_r} + LW'(1);
  assign clr_last = (clr_cnt_r == AW'(MAX_LINE - 1));
  assign load_ok  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdl_pkg::ST_CLEAR:  if (clr_last) state_nxt = fdl_pkg::ST_IDLE;
      fdl_pkg::ST_IDLE:   if (in_valid) state_nxt = fdl_pkg::ST_ADDR;
      fdl_pkg::ST_ADDR:   state_nxt = fdl_pkg::ST_RD_A;
      fdl_pkg::ST_RD_A:   state_nxt = fdl_pkg::ST_RD_B;
      fdl_pkg::ST_RD_B:   state_nxt = fdl_pkg::ST_DIFF;
      fdl_pkg::ST_DIFF:   state_nxt = fdl_pkg::ST_MUL_F;
      fdl_pkg::ST_MUL_F:  state_nxt = fdl_pkg::ST_BLEND;
      fdl_pkg::ST_BLEND:  state_nxt = fdl_pkg::ST_MUL_HI;
      fdl_pkg::ST_MUL_HI: state_nxt = fdl_pkg::ST_MUL_LO;
      fdl_pkg::ST_MUL_LO: state_nxt = fdl_pkg::ST_SUM;
      fdl_pkg::ST_SUM:    state_nxt = fdl_pkg::ST_SAT;
      fdl_pkg::ST_SAT:    if (load_ok) state_nxt = fdl_pkg::ST_IDLE;
      default:            state_nxt = fdl_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl         = '0;
    ctl.mul_sel = fdl_pkg::MUL_DIFF_F;
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = wpe_r;
    ram_raddr   = rd0_r;
    case (state_r)
      fdl_pkg::ST_CLEAR: begin
        ctl.clear = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
      end
      fdl_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.take_in = in_valid;
      end
      fdl_pkg::ST_RD_B: begin
        ram_raddr = rd1;
        ctl.cap_a = 1'b1;
      end
      fdl_pkg::ST_DIFF: begin
        ctl.cap_diff = 1'b1;
        ram_we       = 1'b1;
      end
      fdl_pkg::ST_MUL_F: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = fdl_pkg::MUL_DIFF_F;
      end
      fdl_pkg::ST_BLEND: begin
        ctl.cap_blend = 1'b1;
      end
      fdl_pkg::ST_MUL_HI: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = fdl_pkg::MUL_HI_G;
      end
      fdl_pkg::ST_MUL_LO: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = fdl_pkg::MUL_LO_G;
        ctl.cap_hi  = 1'b1;
      end
      fdl_pkg::ST_SUM: begin
        ctl.cap_sum = 1'b1;
      end
      fdl_pkg::ST_SAT: begin
        ctl.load_out = load_ok;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    wp_nxt        = wp_r;
    wpe_nxt       = wpe_r;
    len_nxt       = len_r;
    dly_nxt       = dly_r;
    frac_nxt      = frac_r;
    rd0_nxt       = rd0_r;
    out_valid_nxt = out_valid_r;
    if (state_r == fdl_pkg::ST_CLEAR) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
    end
    if (state_r == fdl_pkg::ST_IDLE && in_valid) begin
      len_nxt  = len_c;
      dly_nxt  = dly_c;
      wpe_nxt  = wp_c;
      frac_nxt = (dly_c == len_c) ? '0 : delay_frac;
    end
    if (state_r == fdl_pkg::ST_ADDR) begin
      rd0_nxt = ({1'b0, wpe_r} >= dly_r) ? AW'(back) : AW'(back + len_r);
    end
    if (state_r == fdl_pkg::ST_DIFF) begin
      wp_nxt = (wp_inc >= len_r) ? '0 : AW'(wp_inc);
    end
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fdl_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wpe_r  <= wpe_nxt;
    len_r  <= len_nxt;
    dly_r  <= dly_nxt;
    frac_r <= frac_nxt;
    rd0_r  <= rd0_nxt;
  end

  assign out_valid = out_valid_r;
  assign frac      = frac_r;

  `FDL_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!in_ready && !out_valid), "busy after reset")
  `FDL_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state_r == fdl_pkg::ST_ADDR), "accept lost")
  `FDL_ASSERT(a_load_no_overwrite, ctl.load_out |-> (!out_valid_r || out_ready), "result overwritten")
  `FDL_ASSERT(a_write_in_line, (ram_we && !ctl.clear) |-> ({1'b0, ram_waddr} < len_r), "write outside line")
  `FDL_ASSERT(a_read_in_line, (state_r == fdl_pkg::ST_RD_B) |-> ({1'b0, ram_raddr} < len_r), "read outside line")

endmodule

`default_nettype wire

>>> tb/tb_fractional_delay_line.sv
// ----------------------------------------------------------------------------
// Fractional delay line testbench
// Streams audio samples through the delay line under a sequence of line
// lengths, delays, fractions and gains, and checks every output beat against
// an in-bench prediction of the interpolated, gained and saturated sample.
// Both channels idle at random, the receiver holds off once for a long
// stretch, and register writes happen only while the block is idle.
// ----------------------------------------------------------------------------

module tb_fractional_delay_line;
  timeunit 1ns;
  timeprecision 1ps;

  import fdl_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam logic signed [SB-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SB-1:0] SAMPLE_MIN = 24'sh800000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'hFF;
  localparam logic [CFG_DATA_W-1:0] GAIN_UNITY = 16'd4096;
  localparam int SPARE_W = CFG_DATA_W - LEN_CFG_W;
  localparam int SETTLE_CYCLES = 14;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1727;
  localparam int MAX_REPORTS = 10;

  class delay_line_tracker;
    logic signed [SB-1:0]  line_mem [MAX_LINE_DEF];
    int                    wr_pos;
    logic [LEN_CFG_W-1:0]  len_reg;
    logic [LEN_CFG_W-1:0]  delay_reg;
    logic [FRAC_W-1:0]     frac_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic signed [SB-1:0]  expected_out [$];
    int                    mismatches;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      wr_pos     = 0;
      len_reg    = LINE_LENGTH_RST;
      delay_reg  = DELAY_WHOLE_RST;
      frac_reg   = DELAY_FRAC_RST;
      gain_reg   = MAKEUP_GAIN_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LINE_LENGTH: len_reg = data[LEN_CFG_W-1:0];
        REG_DELAY_WHOLE: delay_reg = data[LEN_CFG_W-1:0];
        REG_DELAY_FRAC:  frac_reg = data[FRAC_W-1:0];
        REG_MAKEUP_GAIN: gain_reg = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [SB-1:0] s);
      int     len, d, wp, rd0, rd1;
      longint f, a, b, blend, prod, res;
      longint hi, lo;
      len = len_reg;
      if (len < 2) len = 2;
      if (len > MAX_LINE_DEF) len = MAX_LINE_DEF;
      d = delay_reg;
      if (d < 1) d = 1;
      if (d > len) d = len;
      f = (d == len) ? 0 : longint'(frac_reg);
      wp = wr_pos;
      if (wp >= len) wp = 0;
      rd0 = (wp >= d) ? wp - d : wp + len - d;
      rd1 = (rd0 == 0) ? len - 1 : rd0 - 1;
      a = line_mem[rd0];
      b = line_mem[rd1];
      blend = a * (longint'(65536) - f) + b * f;
      prod = blend * longint'(gain_reg);
      res = (prod + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      hi = (longint'(1) << (SB - 1)) - 1;
      lo = -hi - 1;
      if (res > hi) res = hi;
      if (res < lo) res = lo;
      expected_out.push_back(res[SB-1:0]);
      line_mem[wp] = s;
      wp++;
      if (wp >= len) wp = 0;
      wr_pos = wp;
    endfunction

    function void check_output(logic signed [SB-1:0] got);
      logic signed [SB-1:0] exp_s;
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("sample_out %0d arrived with no sample outstanding", got);
      end else begin
        exp_s = expected_out.pop_front();
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("sample_out mismatch: expected %0d, got %0d", exp_s, got);
        end
      end
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic signed [SB-1:0]   in_sample_in = '0;
  logic                   out_ready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_ready;
  logic                   out_valid;
  logic signed [SB-1:0]   out_sample_out;
  logic                   cfg_ready;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  delay_line_tracker tracker = new();

  always #5 clk = ~clk;

  fractional_delay_line i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) tracker.check_output(out_sample_out);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic push_sample(input logic signed [SB-1:0] s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.note_sample(s);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.write_reg(idx, data);
  endtask

  task automatic cfg_close();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] with_spare_bits(int v);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'(v & 'h1FFF);
    if ($urandom_range(3) == 0) d[CFG_DATA_W-1:LEN_CFG_W] = SPARE_W'($urandom_range(7));
    return d;
  endfunction

  task automatic random_setup();
    int pick, len_v, dly_v;
    logic [CFG_DATA_W-1:0] frac_v, gain_v;
    pick = $urandom_range(99);
    if (pick < 70) len_v = $urandom_range(2, 40);
    else if (pick < 80) begin
      case ($urandom_range(4))
        0: len_v = 0;
        1: len_v = 1;
        2: len_v = 2;
        3: len_v = MAX_LINE_DEF;
        default: len_v = 8191;
      endcase
    end else if (pick < 90) len_v = $urandom_range(41, MAX_LINE_DEF);
    else len_v = $urandom_range(0, 8191);
    pick = $urandom_range(99);
    if (pick < 60) dly_v = $urandom_range(0, len_v + 1);
    else if (pick < 75) dly_v = len_v;
    else if (pick < 85) dly_v = $urandom_range(0, 1);
    else dly_v = $urandom_range(0, 8191);
    pick = $urandom_range(99);
    if (pick < 15) frac_v = '0;
    else if (pick < 30) frac_v = '1;
    else frac_v = CFG_DATA_W'($urandom());
    pick = $urandom_range(99);
    if (pick < 10) gain_v = '0;
    else if (pick < 20) gain_v = '1;
    else if (pick < 30) gain_v = GAIN_UNITY;
    else if (pick < 80) gain_v = CFG_DATA_W'($urandom_range(0, 8192));
    else gain_v = CFG_DATA_W'($urandom());
    if ($urandom_range(4) != 0) cfg_write(REG_LINE_LENGTH, with_spare_bits(len_v));
    if ($urandom_range(4) != 0) cfg_write(REG_DELAY_WHOLE, with_spare_bits(dly_v));
    if ($urandom_range(4) != 0) cfg_write(REG_DELAY_FRAC, frac_v);
    if ($urandom_range(4) != 0) cfg_write(REG_MAKEUP_GAIN, gain_v);
    if ($urandom_range(9) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                CFG_DATA_W'($urandom()));
    cfg_close();
  endtask

  function automatic logic signed [SB-1:0] random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return SAMPLE_MAX;
    if (pick < 16) return SAMPLE_MIN;
    if (pick < 30) return SB'($urandom_range(0, 512) - 256);
    return SB'($urandom());
  endfunction

  initial begin
    int sent, n;
    bit hold_done;
    tx_idle_pct = 38;
    rx_idle_pct = 53;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);

    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample('0);
    push_sample(SB'(-1));
    settle();

    cfg_write(REG_LINE_LENGTH, 16'd0);
    cfg_write(REG_DELAY_WHOLE, 16'd0);
    cfg_write(REG_DELAY_FRAC, 16'hFFFF);
    cfg_write(REG_MAKEUP_GAIN, 16'hFFFF);
    cfg_write(REG_SPARE_LO, 16'h1234);
    cfg_write(REG_SPARE_HI, 16'hFFFF);
    cfg_close();
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_MIN);
    push_sample(SB'(1));
    settle();

    cfg_write(REG_LINE_LENGTH, 16'hFFFF);
    cfg_write(REG_DELAY_WHOLE, 16'd5000);
    cfg_write(REG_DELAY_FRAC, 16'd1);
    cfg_write(REG_MAKEUP_GAIN, GAIN_UNITY);
    cfg_close();
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    settle();

    cfg_write(REG_LINE_LENGTH, 16'd16);
    cfg_write(REG_DELAY_WHOLE, 16'd3);
    cfg_write(REG_DELAY_FRAC, 16'd32768);
    cfg_close();
    repeat (8) push_sample(random_sample());
    settle();

    cfg_write(REG_LINE_LENGTH, 16'd3);
    cfg_write(REG_DELAY_WHOLE, 16'd7);
    cfg_write(REG_DELAY_FRAC, 16'd40000);
    cfg_write(REG_MAKEUP_GAIN, 16'd8192);
    cfg_close();
    repeat (4) push_sample(random_sample());
    settle();

    sent = 0;
    hold_done = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 38;
        rx_idle_pct = 53;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 53;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_setup();
      n = $urandom_range(10, 60);
      // Stall the output for a long stretch while samples keep arriving.
      if (tx_idle_pct == 0 && !hold_done) begin
        hold_req = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      repeat (n) push_sample(random_sample());
      sent += n;
      settle();
    end

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("[fractional_delay_line] OK");
    end else begin
      $display("[fractional_delay_line] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[fractional_delay_line] ERROR");
    $finish;
  end

endmodule
